FILE: hw/rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// TPDF dither quantizer package
// Shared types, output format codes, range limits and the xorshift32 seed
// constants used by the dither generator.
// ----------------------------------------------------------------------------
package tdq_pkg;

   // Output format codes held in the format register.
   typedef enum logic [1:0] {
      FMT_INT16   = 2'd0,
      FMT_INT24   = 2'd1,
      FMT_INT32   = 2'd2,
      FMT_FLOAT32 = 2'd3
   } fmt_type;

   // Control from the request stage to the dither generator.
   typedef struct packed {
      logic advance;   // a request moves into the result register
      logic clear;     // the request asks for a reseed
      logic dither;    // the request uses dither (integer formats)
   } dither_ctrl_type;

   localparam int SampleWidth = 36;
   localparam int LimWidth    = 32;
   localparam int WordWidth   = 32;
   localparam int DsumWidth   = 33;
   localparam int AccWidth    = 34;

   localparam logic [31:0] SEED_VALUE = 32'h9e37_79b9;

   // One xorshift32 step.
   function automatic logic [31:0] xorshift32(input logic [31:0] x);
      logic [31:0] v;
      v = x;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   // The two draws that follow a reseed, worked out at elaboration.
   localparam logic [31:0] SEED_R1 = xorshift32(SEED_VALUE);
   localparam logic [31:0] SEED_R2 = xorshift32(SEED_R1);
   localparam logic [DsumWidth-1:0] SEED_DSUM =
      {1'b0, SEED_R1} + {1'b0, SEED_R2};

   // Clip limits of the Q5.31 input and rails of the integer formats.
   localparam logic signed [LimWidth-1:0] LIM_MAX = 32'sh7fff_ffff;
   localparam logic signed [LimWidth-1:0] LIM_MIN = 32'sh8000_0000;
   localparam logic signed [AccWidth-1:0] Q16_MAX = 34'sd32767;
   localparam logic signed [AccWidth-1:0] Q16_MIN = -34'sd32768;
   localparam logic signed [AccWidth-1:0] Q24_MAX = 34'sd8388607;
   localparam logic signed [AccWidth-1:0] Q24_MIN = -34'sd8388608;
   localparam logic signed [AccWidth-1:0] Q32_MAX = 34'sd2147483647;
   localparam logic signed [AccWidth-1:0] Q32_MIN = -34'sd2147483648;

   localparam logic [7:0] FLOAT_EXP_BIAS = 8'd96;

endpackage

FILE: hw/rtl/tdq_dither.sv
// ----------------------------------------------------------------------------
// TPDF dither generator
// Keeps the xorshift32 state and the sum of the next two draws in registers,
// so the sum is ready at the start of the cycle that consumes it.
// ----------------------------------------------------------------------------
module tdq_dither
   import tdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dither_ctrl_type       ctrl,
   output logic [DsumWidth-1:0]  dsum
);

   logic [31:0]          gen_ff;    // state after the pending pair of draws
   logic [31:0]          gen_in;
   logic [DsumWidth-1:0] dsum_ff;   // sum of the pending pair of draws
   logic [DsumWidth-1:0] dsum_in;
   logic [31:0]          base;
   logic [31:0]          r1;
   logic [31:0]          r2;

   // A reseed replaces the pending pair with the pair that follows the seed.
   assign dsum = ctrl.clear ? SEED_DSUM : dsum_ff;
   assign base = ctrl.clear ? SEED_R2 : gen_ff;

   // Look ahead by two draws for the next request.
   always_comb begin
      r1      = xorshift32(base);
      r2      = xorshift32(r1);
      gen_in  = gen_ff;
      dsum_in = dsum_ff;
      if (ctrl.advance) begin
         if (ctrl.dither) begin
            gen_in  = r2;
            dsum_in = {1'b0, r1} + {1'b0, r2};
         end else if (ctrl.clear) begin
            gen_in  = SEED_R2;
            dsum_in = SEED_DSUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= SEED_R2;
         dsum_ff <= SEED_DSUM;
      end else begin
         gen_ff  <= gen_in;
         dsum_ff <= dsum_in;
      end
   end

endmodule

FILE: hw/rtl/tdq_quant.sv
// ----------------------------------------------------------------------------
// Dithered integer requantizer
// Adds the dither sum to the dropped fraction, rounds half away from zero
// and clamps to the rails of the selected integer format.
// ----------------------------------------------------------------------------
module tdq_quant
   import tdq_pkg::*;
(
   input  fmt_type                     fmt,
   input  logic signed [LimWidth-1:0]  lim,
   input  logic [DsumWidth-1:0]        dsum,
   output logic [WordWidth-1:0]        bits
);

   logic signed [AccWidth-1:0] ipart;
   logic [31:0]                lowsh;
   logic [AccWidth-1:0]        total;
   logic signed [AccWidth-1:0] k;
   logic signed [AccWidth-1:0] n;
   logic                       rbit;
   logic signed [AccWidth-1:0] res;
   logic signed [AccWidth-1:0] hi;
   logic signed [AccWidth-1:0] lo;
   logic signed [AccWidth-1:0] clamped;

   // Split the value into the kept integer part and the dropped fraction.
   always_comb begin
      case (fmt)
         FMT_INT16: begin
            ipart = {{18{lim[31]}}, lim[31:16]};
            lowsh = {lim[15:0], 16'h0000};
            hi    = Q16_MAX;
            lo    = Q16_MIN;
         end
         FMT_INT24: begin
            ipart = {{10{lim[31]}}, lim[31:8]};
            lowsh = {lim[7:0], 24'h00_0000};
            hi    = Q24_MAX;
            lo    = Q24_MIN;
         end
         default: begin
            ipart = {{2{lim[31]}}, lim};
            lowsh = 32'h0;
            hi    = Q32_MAX;
            lo    = Q32_MIN;
         end
      endcase
   end

   // Fraction plus dither; the carry moves the integer part by -1 to +1.
   assign total = {2'b00, lowsh} + {1'b0, dsum};
   assign k     = $signed({32'h0, total[33:32]}) - 34'sd1;
   assign n     = ipart + k;

   // Half rounds away from zero.
   assign rbit = n[AccWidth-1] ? (total[31] && (|total[30:0])) : total[31];
   assign res  = n + $signed({33'h0, rbit});

   always_comb begin
      if (res > hi) begin
         clamped = hi;
      end else if (res < lo) begin
         clamped = lo;
      end else begin
         clamped = res;
      end
   end

   // Pack in the low bits with the upper bits zero.
   always_comb begin
      case (fmt)
         FMT_INT16: bits = {16'h0000, clamped[15:0]};
         FMT_INT24: bits = {8'h00, clamped[23:0]};
         default:   bits = clamped[31:0];
      endcase
   end

endmodule

FILE: hw/rtl/tdq_float.sv
// ----------------------------------------------------------------------------
// Fixed to float converter
// Converts a clipped Q1.31 value to IEEE single precision with round to
// nearest even.
// ----------------------------------------------------------------------------
module tdq_float
   import tdq_pkg::*;
(
   input  logic signed [LimWidth-1:0] lim,
   output logic [WordWidth-1:0]       bits
);

   logic        sign;
   logic [31:0] mag;
   logic [4:0]  msb;
   logic [31:0] norm;
   logic        round_up;
   logic [24:0] keep;
   logic [7:0]  expo;

   assign sign = lim[31];
   assign mag  = sign ? (32'h0 - lim) : lim;

   // Position of the leading one.
   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            msb = 5'(i);
         end
      end
   end

   // Normalize so the leading one sits at bit 31, then round at bit 8.
   assign norm     = mag << (5'd31 - msb);
   assign round_up = norm[7] && ((|norm[6:0]) || norm[8]);
   assign keep     = {1'b0, norm[31:8]} + {24'h0, round_up};
   assign expo     = {3'b000, msb} + FLOAT_EXP_BIAS + {7'h0, keep[24]};

   always_comb begin
      if (mag == 32'h0) begin
         bits = 32'h0;
      end else if (keep[24]) begin
         bits = {sign, expo, 23'h0};
      end else begin
         bits = {sign, expo, keep[22:0]};
      end
   end

endmodule

FILE: hw/rtl/tpdf_dither_quantizer.sv
// ----------------------------------------------------------------------------
// TPDF dither quantizer
// The request register loads at the accept and the result register loads when the
// request moves on. Throughput: one request per cycle while rsp_ready holds, set by
// the combinational clip, dither add and round path.
// Synchronous active-high reset sets the format to int16, seeds the generator
// and zeroes the clip count.
// ----------------------------------------------------------------------------
module tpdf_dither_quantizer
   import tdq_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SampleWidth-1:0]  req_sample,
   input  logic                           req_clear,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [WordWidth-1:0]           rsp_sample_bits,
   output logic                           rsp_clipped,
   output logic [31:0]                    rsp_clip_count
);

   fmt_type                     fmt_ff;
   logic                        req_valid_ff;
   logic                        req_valid_in;
   logic signed [SampleWidth-1:0] sample_ff;
   logic                        clear_ff;
   logic                        advance;
   logic                        clip_hi;
   logic                        clip_lo;
   logic                        clipped;
   logic signed [LimWidth-1:0]  lim;
   logic [31:0]                 count_ff;
   logic [31:0]                 count_base;
   logic [31:0]                 count_in;
   logic [DsumWidth-1:0]        dsum;
   dither_ctrl_type             dctrl;
   logic [WordWidth-1:0]        int_bits;
   logic [WordWidth-1:0]        flt_bits;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [WordWidth-1:0]        bits_ff;
   logic                        clipped_ff;
   logic [31:0]                 rsp_count_ff;

   // Format register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_INT16;
      end else if (csr_wr_en) begin
         fmt_ff <= fmt_type'(csr_wr_data);
      end
   end

   // Handshake: the request register moves on when the result slot frees.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_sample;
         clear_ff  <= req_clear;
      end
   end

   // Clip to the full-scale range of a Q1.31 value.
   assign clip_hi = !sample_ff[35] && (|sample_ff[34:31]);
   assign clip_lo = sample_ff[35] && !(&sample_ff[34:31]);
   assign clipped = clip_hi || clip_lo;

   always_comb begin
      if (clip_hi) begin
         lim = LIM_MAX;
      end else if (clip_lo) begin
         lim = LIM_MIN;
      end else begin
         lim = sample_ff[31:0];
      end
   end

   // Saturating clip counter, zeroed first when the request asks for it.
   assign count_base = clear_ff ? 32'h0 : count_ff;
   assign count_in   = count_base + {31'h0, (clipped && (count_base != 32'hffff_ffff))};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 32'h0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

   // Dither generator steps only for integer formats.
   assign dctrl.advance = advance;
   assign dctrl.clear   = clear_ff;
   assign dctrl.dither  = (fmt_ff != FMT_FLOAT32);

   tdq_dither u_dither (
      .clock (clock),
      .reset (reset),
      .ctrl  (dctrl),
      .dsum  (dsum)
   );

   tdq_quant u_quant (
      .fmt  (fmt_ff),
      .lim  (lim),
      .dsum (dsum),
      .bits (int_bits)
   );

   tdq_float u_float (
      .lim  (lim),
      .bits (flt_bits)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bits_ff      <= (fmt_ff == FMT_FLOAT32) ? flt_bits : int_bits;
         clipped_ff   <= clipped;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_bits = bits_ff;
   assign rsp_clipped     = clipped_ff;
   assign rsp_clip_count  = rsp_count_ff;

endmodule
